// ===== hdl/fprc_pkg.sv =====
`default_nettype none

package fprc_pkg;

   localparam int unsigned MAX_TYPES = 16;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [4:0] TYPE_COUNT_RESET = 5'd16;

   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 6;

   typedef enum logic [2:0] {
      PH_HUNT1  = 3'd0,
      PH_HUNT2  = 3'd1,
      PH_NUMBER = 3'd2,
      PH_TYPE   = 3'd3,
      PH_DATA   = 3'd4,
      PH_CRC1   = 3'd5,
      PH_CRC2   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PAYLOAD = 3'd1,
      EV_GOOD    = 3'd2,
      EV_BADCRC  = 3'd3,
      EV_BADTYPE = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      REG_FIRST_SYNC  = 3'd0,
      REG_SECOND_SYNC = 3'd1,
      REG_TYPE_COUNT  = 3'd2,
      REG_SIZE_LOW    = 3'd3,
      REG_SIZE_HIGH   = 3'd4,
      REG_ACK_EXEMPT  = 3'd5
   } reg_index_type;

   function automatic logic [15:0] fprc_crc_byte(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] fprc_size_of_type(input logic [63:0] low_word,
                                                    input logic [63:0] high_word,
                                                    input logic [3:0]  t);
      logic [63:0] word;
      word = t[3] ? high_word : low_word;
      return word[{t[2:0], 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/framed_packet_receiver_crc16_top.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_rx_byte
// rsp      out        rsp_valid/rsp_stall   rsp_event_res, rsp_frame_number, rsp_frame_type,
//                                           rsp_payload_byte, rsp_payload_index, rsp_ack_due
// csr      in/out     csr_psel/csr_penable  csr_paddr, csr_pwrite, csr_pwdata, csr_prdata
//
// One item per cycle while req_stall is low; each item yields one result in the cycle after acceptance.
// The frame state and the CRC update for an item settle in the cycle it is accepted.
// The single result register sets the rate: req_stall rises only while it is full and stalled.
// Synchronous active-high reset returns to the sync hunt and restores register defaults.
`default_nettype none

module framed_packet_receiver_crc16_top
   import fprc_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,

   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire  [7:0]             req_rx_byte,

   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [2:0]             rsp_event_res,
   output logic [7:0]             rsp_frame_number,
   output logic [3:0]             rsp_frame_type,
   output logic [7:0]             rsp_payload_byte,
   output logic [7:0]             rsp_payload_index,
   output logic                   rsp_ack_due,

   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [7:0]    first_sync_ff;
   logic [7:0]    second_sync_ff;
   logic [4:0]    type_count_ff;
   logic [63:0]   size_low_ff;
   logic [63:0]   size_high_ff;
   logic [15:0]   ack_exempt_ff;

   phase_type     phase_ff, phase_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    crc_high_ff, crc_high_in;
   logic [7:0]    count_ff, count_in;
   logic [7:0]    length_ff, length_in;
   logic [3:0]    type_ff, type_in;
   logic [7:0]    number_ff, number_in;

   logic          rsp_valid_ff, rsp_valid_in;
   event_type     event_ff, event_in;
   logic [7:0]    out_number_ff, out_number_in;
   logic [3:0]    out_type_ff, out_type_in;
   logic [7:0]    out_pbyte_ff, out_pbyte_in;
   logic [7:0]    out_pindex_ff, out_pindex_in;
   logic          out_ack_ff, out_ack_in;

   logic          accept;
   logic          csr_write;
   reg_index_type csr_index;
   logic [4:0]    type_limit;
   logic          type_bad;
   logic [15:0]   crc_next;
   logic [7:0]    type_size;
   logic [7:0]    count_next;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sync_ff  <= '0;
         second_sync_ff <= '0;
         type_count_ff  <= TYPE_COUNT_RESET;
         size_low_ff    <= '0;
         size_high_ff   <= '0;
         ack_exempt_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_FIRST_SYNC:  first_sync_ff  <= csr_pwdata[7:0];
            REG_SECOND_SYNC: second_sync_ff <= csr_pwdata[7:0];
            REG_TYPE_COUNT:  type_count_ff  <= csr_pwdata[4:0];
            REG_SIZE_LOW:    size_low_ff    <= csr_pwdata;
            REG_SIZE_HIGH:   size_high_ff   <= csr_pwdata;
            REG_ACK_EXEMPT:  ack_exempt_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FIRST_SYNC:  csr_prdata = {56'h0, first_sync_ff};
         REG_SECOND_SYNC: csr_prdata = {56'h0, second_sync_ff};
         REG_TYPE_COUNT:  csr_prdata = {59'h0, type_count_ff};
         REG_SIZE_LOW:    csr_prdata = size_low_ff;
         REG_SIZE_HIGH:   csr_prdata = size_high_ff;
         REG_ACK_EXEMPT:  csr_prdata = {48'h0, ack_exempt_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign type_limit = (type_count_ff < 5'(MAX_TYPES)) ? type_count_ff : 5'(MAX_TYPES);
   assign type_bad   = ({3'b000, type_limit} <= req_rx_byte);
   assign crc_next   = fprc_crc_byte(crc_ff, req_rx_byte);
   assign type_size  = fprc_size_of_type(size_low_ff, size_high_ff, req_rx_byte[3:0]);
   assign count_next = count_ff + 8'd1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_HUNT1: begin
               if (req_rx_byte == first_sync_ff) phase_in = PH_HUNT2;
            end
            PH_HUNT2: begin
               if (req_rx_byte == second_sync_ff) phase_in = PH_NUMBER;
            end
            PH_NUMBER: phase_in = PH_TYPE;
            PH_TYPE: begin
               if (type_bad) begin
                  phase_in = PH_HUNT1;
               end else if (type_size != 8'd0) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_CRC1;
               end
            end
            PH_DATA: begin
               if (count_next == length_ff) phase_in = PH_CRC1;
            end
            PH_CRC1: phase_in = PH_CRC2;
            PH_CRC2: phase_in = PH_HUNT1;
            default: phase_in = PH_HUNT1;
         endcase
      end
   end

   // frame datapath and result
   always_comb begin
      crc_in        = crc_ff;
      crc_high_in   = crc_high_ff;
      count_in      = count_ff;
      length_in     = length_ff;
      type_in       = type_ff;
      number_in     = number_ff;
      event_in      = EV_NONE;
      out_number_in = '0;
      out_type_in   = '0;
      out_pbyte_in  = '0;
      out_pindex_in = '0;
      out_ack_in    = 1'b0;
      case (phase_ff)
         PH_HUNT2: begin
            if (req_rx_byte == second_sync_ff) begin
               count_in = '0;
               crc_in   = CRC_INIT;
            end
         end
         PH_NUMBER: begin
            number_in = req_rx_byte;
            crc_in    = crc_next;
         end
         PH_TYPE: begin
            if (type_bad) begin
               event_in      = EV_BADTYPE;
               out_number_in = number_ff;
            end else begin
               type_in   = req_rx_byte[3:0];
               length_in = type_size;
               crc_in    = crc_next;
            end
         end
         PH_DATA: begin
            event_in      = EV_PAYLOAD;
            out_number_in = number_ff;
            out_type_in   = type_ff;
            out_pbyte_in  = req_rx_byte;
            out_pindex_in = count_ff;
            crc_in        = crc_next;
            count_in      = count_next;
         end
         PH_CRC1: crc_high_in = req_rx_byte;
         PH_CRC2: begin
            out_number_in = number_ff;
            out_type_in   = type_ff;
            if ({crc_high_ff, req_rx_byte} == crc_ff) begin
               event_in   = EV_GOOD;
               out_ack_in = ~ack_exempt_ff[type_ff];
            end else begin
               event_in   = EV_BADCRC;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         crc_ff        <= crc_in;
         crc_high_ff   <= crc_high_in;
         count_ff      <= count_in;
         length_ff     <= length_in;
         type_ff       <= type_in;
         number_ff     <= number_in;
         event_ff      <= event_in;
         out_number_ff <= out_number_in;
         out_type_ff   <= out_type_in;
         out_pbyte_ff  <= out_pbyte_in;
         out_pindex_ff <= out_pindex_in;
         out_ack_ff    <= out_ack_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = event_ff;
   assign rsp_frame_number  = out_number_ff;
   assign rsp_frame_type    = out_type_ff;
   assign rsp_payload_byte  = out_pbyte_ff;
   assign rsp_payload_index = out_pindex_ff;
   assign rsp_ack_due       = out_ack_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with result register empty");

   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_data_has_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> length_ff != 8'd0)
      else $error("payload phase with zero length");

   a_ack_only_on_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ack_due |-> event_ff == EV_GOOD)
      else $error("acknowledge flagged on a frame that is not good");

   a_none_is_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_ff == EV_NONE |->
         rsp_frame_number == 8'd0 && rsp_frame_type == 4'd0 &&
         rsp_payload_byte == 8'd0 && rsp_payload_index == 8'd0)
      else $error("empty result carries nonzero fields");

endmodule

`default_nettype wire
